// File: rtl/ucvb_pkg.sv
// shared types, constants and the code point to byte mapping
package ucvb_pkg;

  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);

  localparam logic [15:0] VnBase     = 16'h1EA0;
  localparam logic [15:0] VnLen      = 16'h005A;
  localparam logic [15:0] LatinBase  = 16'h00C0;
  localparam int          LatinCount = 46;
  localparam logic [7:0]  Unmapped   = 8'h3F;
  localparam logic [15:0] CodeCr     = 16'h000D;

  localparam logic [7:0] LatinKeys [LatinCount] = '{
    8'h00, 8'h01, 8'h02, 8'h03, 8'h08, 8'h09, 8'h0A, 8'h0C, 8'h0D,
    8'h12, 8'h13, 8'h14, 8'h15, 8'h19, 8'h1A, 8'h1B, 8'h1D,
    8'h20, 8'h21, 8'h22, 8'h23, 8'h28, 8'h29, 8'h2A, 8'h2C, 8'h2D,
    8'h32, 8'h33, 8'h34, 8'h35, 8'h39, 8'h3A, 8'h3B, 8'h3D,
    8'h42, 8'h43, 8'h50, 8'h51, 8'h68, 8'h69, 8'hA8, 8'hA9, 8'hE0, 8'hE1, 8'hEF, 8'hF0
  };

  // one queue entry: one or two code points that each give a byte
  typedef struct packed {
    logic        two;
    logic [15:0] cp0;
    logic [15:0] cp1;
  } ucvb_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } ucvb_qstat_t;

  // code point to vietnamese byte (carriage return never gets here)
  function automatic logic [7:0] map_code(input logic [15:0] cp);
    logic [15:0] i;
    logic [15:0] a;
    logic [7:0]  key;
    logic [7:0]  idx;
    logic        found;
    logic [7:0]  res;
    i     = cp - VnBase;
    a     = cp - LatinBase;
    key   = (a[7:0] == 8'h10) ? 8'h50 : a[7:0];
    found = 1'b0;
    idx   = i[7:0];
    res   = Unmapped;
    for (int k = 0; k < LatinCount; k++) begin
      if (LatinKeys[k] == key) begin
        found = 1'b1;
        idx   = 8'(k) + VnLen[7:0];
      end
    end
    if (cp[15:7] == 9'd0) begin
      res = cp[7:0];
    end else if (i < VnLen) begin
      res = i[7:0] - 8'h80 + {3'd0, i[7], 4'd0};
    end else if (a[15:8] == 8'd0 && found) begin
      res = idx - 8'h80 + {3'd0, idx[7], 4'd0};
    end
    return res;
  endfunction

endpackage

// File: rtl/ucvb_front.sv
// front end: mark detection and utf-8 / utf-16 decoding into code points
module ucvb_front
  import ucvb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  input  logic        kind,
  input  logic [7:0]  data_byte,
  input  ucvb_qstat_t q_stat,
  output logic        push,
  output ucvb_entry_t push_data
);

  typedef enum logic [1:0] {
    PhaseIdle = 2'd0,
    PhaseOne  = 2'd1,
    PhaseEfBb = 2'd2,
    PhaseDone = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ModeNone = 2'd0,
    ModeLe   = 2'd1,
    ModeBe   = 2'd2,
    ModeUtf8 = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0]  pending;
    logic [15:0] partial;
    logic        stopped;
  } dec_st_t;

  typedef struct packed {
    dec_st_t     st;
    logic        emit;
    logic [15:0] cp;
  } dec_res_t;

  function automatic dec_res_t utf8_feed(input dec_st_t st, input logic [7:0] b);
    dec_res_t r;
    r      = '0;
    r.st   = st;
    if (!st.stopped) begin
      if (st.pending == 2'd0) begin
        if (!b[7]) begin
          r.emit = (b != CodeCr[7:0]);
          r.cp   = {8'd0, b};
        end else if (b < 8'hC0 || b >= 8'hF0) begin
          r.st.stopped = 1'b1;
        end else if (b >= 8'hE0) begin
          r.st.pending = 2'd2;
          r.st.partial = {12'd0, b[3:0]};
        end else begin
          r.st.pending = 2'd1;
          r.st.partial = {11'd0, b[4:0]};
        end
      end else if (b[7:6] != 2'b10) begin
        r.st.stopped = 1'b1;
        r.st.pending = 2'd0;
      end else begin
        r.st.partial = {st.partial[9:0], b[5:0]};
        r.st.pending = st.pending - 2'd1;
        if (st.pending == 2'd1) begin
          // an overlong carriage return is dropped as well
          r.emit = ({st.partial[9:0], b[5:0]} != CodeCr);
          r.cp   = {st.partial[9:0], b[5:0]};
        end
      end
    end
    return r;
  endfunction

  phase_t      phase, phase_next;
  mode_t       mode, mode_next;
  logic [7:0]  hdr, hdr_next;
  dec_st_t     dec, dec_next;

  logic        accept;
  logic        em_a, em_b;
  logic [15:0] cp_a, cp_b;
  logic [15:0] unit;

  dec_res_t r_hdr, r_after, r_cur, r_ef, r_bb, r_c;

  assign accept  = valid && !q_stat.full;
  assign r_hdr   = utf8_feed(dec, hdr);
  assign r_after = utf8_feed(r_hdr.st, data_byte);
  assign r_cur   = utf8_feed(dec, data_byte);
  assign r_ef    = utf8_feed(dec, 8'hEF);
  assign r_bb    = utf8_feed(r_ef.st, 8'hBB);
  assign r_c     = utf8_feed(r_bb.st, data_byte);
  assign unit    = (mode == ModeLe) ? {data_byte, dec.partial[7:0]}
                                    : {dec.partial[7:0], data_byte};

  always_comb begin
    phase_next = phase;
    mode_next  = mode;
    hdr_next   = hdr;
    dec_next   = dec;
    em_a       = 1'b0;
    em_b       = 1'b0;
    cp_a       = r_hdr.cp;
    cp_b       = r_cur.cp;
    case (mode)
      ModeNone: begin
        case (phase)
          PhaseOne: begin
            if ({data_byte, hdr} == 16'hFEFF) begin
              mode_next  = ModeLe;
              phase_next = PhaseDone;
            end else if ({data_byte, hdr} == 16'hFFFE) begin
              mode_next  = ModeBe;
              phase_next = PhaseDone;
            end else if ({data_byte, hdr} == 16'hBBEF) begin
              phase_next = PhaseEfBb;
            end else begin
              // no mark: replay the held byte, then this one
              mode_next  = ModeUtf8;
              phase_next = PhaseDone;
              dec_next   = r_after.st;
              em_a       = r_hdr.emit;
              em_b       = r_after.emit;
              cp_b       = r_after.cp;
            end
          end
          PhaseEfBb: begin
            mode_next  = ModeUtf8;
            phase_next = PhaseDone;
            if (data_byte != 8'hBF) begin
              dec_next = r_c.st;
              em_b     = r_c.emit;
              cp_b     = r_c.cp;
            end
          end
          default: begin
            hdr_next   = data_byte;
            phase_next = PhaseOne;
          end
        endcase
      end
      ModeUtf8: begin
        dec_next = r_cur.st;
        em_b     = r_cur.emit;
      end
      default: begin
        if (dec.pending == 2'd0) begin
          dec_next.partial = {8'd0, data_byte};
          dec_next.pending = 2'd1;
        end else begin
          dec_next.partial = 16'd0;
          dec_next.pending = 2'd0;
          em_b             = (unit != CodeCr);
          cp_b             = unit;
        end
      end
    endcase
  end

  assign push           = accept && !kind && (em_a || em_b);
  assign push_data.two  = em_a && em_b;
  assign push_data.cp0  = em_a ? cp_a : cp_b;
  assign push_data.cp1  = cp_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PhaseIdle;
      mode  <= ModeNone;
      hdr   <= 8'd0;
      dec   <= '0;
    end else if (accept) begin
      if (kind) begin
        phase <= PhaseIdle;
        mode  <= ModeNone;
        hdr   <= 8'd0;
        dec   <= '0;
      end else begin
        phase <= phase_next;
        mode  <= mode_next;
        hdr   <= hdr_next;
        dec   <= dec_next;
      end
    end
  end

endmodule

// File: rtl/ucvb_queue.sv
// short queue of decoded code points between front and back
module ucvb_queue
  import ucvb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  ucvb_entry_t push_data,
  input  logic        pop,
  output ucvb_entry_t head,
  output ucvb_qstat_t stat
);

  ucvb_entry_t    slots [QDepth];
  logic [QAw-1:0] wr_ptr, rd_ptr;
  logic [QAw:0]   count;

  assign head       = slots[rd_ptr];
  assign stat.empty = (count == '0);
  assign stat.full  = (count == (QAw+1)'(QDepth));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/ucvb_back.sv
// back end: maps code points to bytes and drives the output register
module ucvb_back
  import ucvb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  ucvb_entry_t head,
  input  ucvb_qstat_t q_stat,
  output logic        pop,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [7:0]  out_byte,
  output logic        last_in_run
);

  logic        sel;
  logic        load;
  logic        take;
  logic        is_last;
  logic [15:0] cp;

  assign load    = !out_valid || !out_stall;
  assign take    = load && !q_stat.empty;
  assign is_last = !head.two || sel;
  assign cp      = sel ? head.cp1 : head.cp0;
  assign pop     = take && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel       <= 1'b0;
    end else if (load) begin
      out_valid <= !q_stat.empty;
      if (take) begin
        sel <= !is_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_byte    <= map_code(cp);
      last_in_run <= is_last;
    end
  end

endmodule

// File: rtl/unicode_to_vietnamese_byte_core.sv
// top level of the unicode to vietnamese 8-bit byte converter
// Takes one byte item per cycle while in_stall is low: kind 1 restarts mark detection,
// kind 0 carries a text byte. The front end detects the byte-order mark and decodes
// utf-8 or utf-16 in the cycle an item is accepted and writes its code points into a
// 4-entry queue; the back end maps one code point per cycle, unless the output stalls,
// into the registered output, each passing a queue slot and then the output register.
// An item that yields two bytes (a mark-less stream whose first two bytes are both
// characters) gives them in turn, other items one byte or none. in_stall rises only
// when the queue is full, so the input side is held back only by output stalls.
module unicode_to_vietnamese_byte_core
  import ucvb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       kind,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       last_in_run
);

  ucvb_qstat_t q_stat;
  ucvb_entry_t push_data;
  ucvb_entry_t head;
  logic        push;
  logic        pop;

  assign in_stall = q_stat.full;

  ucvb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .valid     (in_valid),
    .kind      (kind),
    .data_byte (data_byte),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  ucvb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  ucvb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_stat      (q_stat),
    .pop         (pop),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_byte    (out_byte),
    .last_in_run (last_in_run)
  );

endmodule

// File: rtl/ucvb_checker.sv
// port-level checks for the converter, bound to the top level
module ucvb_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       last_in_run
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last_in_run))
    else $error("output changed while stalled");

  // the second byte of an item follows straight after the first
  a_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_in_run |=> out_valid && last_in_run)
    else $error("second byte of a pair missing");

  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_rst_in: assert property (@(posedge clk) rst |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind unicode_to_vietnamese_byte_core ucvb_checker u_ucvb_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_byte    (out_byte),
  .last_in_run (last_in_run)
);
